>>> hdl/nhrc_pkg.sv
// Shared types, constants and one's-complement helpers for the NAT header rewrite block.
package nhrc_pkg;

	localparam int unsigned QUEUE_DEPTH_DFLT = 4;
	localparam int unsigned ADDR_WORDS       = 8;
	localparam int unsigned IP4_WORDS        = 2;
	localparam int unsigned WORD_W           = 16;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic OP_DST = 1'b0;
	localparam logic OP_SRC = 1'b1;

	// One transaction after classification, as it waits in the queue.
	typedef struct packed {
		logic        is_src;
		logic        ip6;
		logic        tcpudp;
		logic        l4_zero;
		logic [15:0] base_ip;
		logic [15:0] base_l4;
		logic [63:0] old_hi;
		logic [63:0] old_lo;
		logic [63:0] new_hi;
		logic [63:0] new_lo;
		logic        keep;
		logic [15:0] cur_port;
		logic [15:0] xlat_port;
	} item_t;

	// Per-item data that rides along the checksum pipeline.
	typedef struct packed {
		logic        is_src;
		logic        ip6;
		logic        ip_en;
		logic        l4a_en;
		logic        l4_act;
		logic [15:0] base_ip;
		logic [15:0] base_l4;
		logic [15:0] port_sum;
		logic [63:0] res_hi;
		logic [63:0] res_lo;
		logic [15:0] res_port;
	} meta_t;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	function automatic logic is_tcpudp(input logic [7:0] proto);
		return (proto == PROTO_TCP) || (proto == PROTO_UDP);
	endfunction

endpackage

>>> hdl/nhrc_front.sv
// Front end: accepts transactions, tracks the packet's header kind, classifies and masks.
module nhrc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic                 is_ip6,
	input  logic [7:0]           protocol,
	input  logic [15:0]          ip_checksum,
	input  logic [15:0]          l4_checksum,
	input  logic [63:0]          old_addr_hi,
	input  logic [63:0]          old_addr_lo,
	input  logic [63:0]          new_addr_hi,
	input  logic [63:0]          new_addr_lo,
	input  logic [15:0]          cur_port,
	input  logic [15:0]          xlat_port,
	output logic                 push,
	input  logic                 push_ready,
	output nhrc_pkg::item_t      push_item
);
	import nhrc_pkg::*;

	logic kind_ip6_q, kind_tcpudp_q, l4_zero_q;
	logic ip6, tcpudp, l4_zero, is_dst, accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;
	assign push     = accept;
	assign is_dst   = (operation == OP_DST);

	always_comb begin
		if (is_dst) begin
			ip6     = is_ip6;
			tcpudp  = is_tcpudp(protocol);
			l4_zero = is_tcpudp(protocol) && (l4_checksum == 16'd0);
		end else begin
			ip6     = kind_ip6_q;
			tcpudp  = kind_tcpudp_q;
			l4_zero = l4_zero_q;
		end
	end

	always_comb begin
		push_item.is_src    = !is_dst;
		push_item.ip6       = ip6;
		push_item.tcpudp    = tcpudp;
		push_item.l4_zero   = l4_zero;
		push_item.base_ip   = ip6 ? ip_checksum : ~ip_checksum;
		push_item.base_l4   = (tcpudp && !l4_zero) ? ~l4_checksum : l4_checksum;
		push_item.old_hi    = ip6 ? old_addr_hi : 64'd0;
		push_item.old_lo    = ip6 ? old_addr_lo : {32'd0, old_addr_lo[31:0]};
		push_item.new_hi    = ip6 ? new_addr_hi : 64'd0;
		push_item.new_lo    = ip6 ? new_addr_lo : {32'd0, new_addr_lo[31:0]};
		push_item.keep      = ((push_item.new_hi | push_item.new_lo) == 64'd0);
		push_item.cur_port  = cur_port;
		push_item.xlat_port = xlat_port;
	end

	// Latch the header kind on every accepted destination transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_ip6_q    <= 1'b0;
			kind_tcpudp_q <= 1'b0;
			l4_zero_q     <= 1'b0;
		end else if (accept && is_dst) begin
			kind_ip6_q    <= ip6;
			kind_tcpudp_q <= tcpudp;
			l4_zero_q     <= l4_zero;
		end
	end

endmodule

>>> hdl/nhrc_queue.sv
// Short queue between the front end and the checksum back end.
module nhrc_queue #(
	parameter int unsigned DEPTH = nhrc_pkg::QUEUE_DEPTH_DFLT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      push_ready,
	input  nhrc_pkg::item_t           push_item,
	output logic                      pop_valid,
	input  logic                      pop,
	output nhrc_pkg::item_t           pop_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import nhrc_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign count      = count_q;
	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> hdl/nhrc_back.sv
// Back end: pipelined one's-complement checksum update, packet state and result register.
module nhrc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  nhrc_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          out_ip_checksum,
	output logic [15:0]          out_l4_checksum,
	output logic [63:0]          out_dst_addr_hi,
	output logic [63:0]          out_dst_addr_lo,
	output logic [63:0]          out_src_addr_hi,
	output logic [63:0]          out_src_addr_lo,
	output logic [15:0]          out_dst_port,
	output logic [15:0]          out_src_port
);
	import nhrc_pkg::*;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	meta_t meta_c, meta_s1, meta_s2, meta_s3;
	logic [15:0] word_c [ADDR_WORDS];
	logic [15:0] word_s1 [ADDR_WORDS];
	logic [15:0] pair_s2 [ADDR_WORDS/2];
	logic [15:0] quad_s3 [2];
	logic [127:0] old_cat, new_cat;

	logic [15:0] ip_sum_q, l4_sum_q;
	logic [63:0] held_hi_q, held_lo_q;
	logic [15:0] held_port_q;

	logic [15:0] addr_sum, base_ip, base_l4, ip_new, l4_new;

	// Advance the whole pipeline whenever the result slot is free or being taken.
	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && q_valid;
	assign out_valid = out_valid_q;

	assign old_cat = {q_item.old_hi, q_item.old_lo};
	assign new_cat = {q_item.new_hi, q_item.new_lo};

	always_comb begin
		for (int i = 0; i < ADDR_WORDS; i++) begin
			if ((i < IP4_WORDS) || q_item.ip6) begin
				word_c[i] = oc_add(~old_cat[WORD_W*i +: WORD_W], new_cat[WORD_W*i +: WORD_W]);
			end else begin
				word_c[i] = '0;
			end
		end
	end

	always_comb begin
		meta_c.is_src  = q_item.is_src;
		meta_c.ip6     = q_item.ip6;
		meta_c.ip_en   = !q_item.ip6 && !q_item.keep;
		meta_c.l4a_en  = q_item.tcpudp && !q_item.l4_zero && !q_item.keep;
		meta_c.l4_act  = q_item.tcpudp && !q_item.l4_zero;
		meta_c.base_ip = q_item.base_ip;
		meta_c.base_l4 = q_item.base_l4;
		meta_c.res_hi  = q_item.keep ? q_item.old_hi : q_item.new_hi;
		meta_c.res_lo  = q_item.keep ? q_item.old_lo : q_item.new_lo;
		if (q_item.tcpudp && !q_item.l4_zero && (q_item.xlat_port != 16'd0)) begin
			meta_c.port_sum = oc_add(~q_item.cur_port, q_item.xlat_port);
		end else begin
			meta_c.port_sum = '0;
		end
		if (!q_item.tcpudp) begin
			meta_c.res_port = q_item.cur_port;
		end else if (q_item.l4_zero || (q_item.xlat_port != 16'd0)) begin
			meta_c.res_port = q_item.xlat_port;
		end else begin
			meta_c.res_port = q_item.cur_port;
		end
	end

	// Fold the last address level, then merge into the running sums.
	always_comb begin
		addr_sum = oc_add(quad_s3[0], quad_s3[1]);
		base_ip  = meta_s3.is_src ? ip_sum_q : meta_s3.base_ip;
		base_l4  = meta_s3.is_src ? l4_sum_q : meta_s3.base_l4;
		ip_new   = oc_add(base_ip, meta_s3.ip_en ? addr_sum : 16'd0);
		l4_new   = oc_add(oc_add(base_l4, meta_s3.port_sum),
			meta_s3.l4a_en ? addr_sum : 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			ip_sum_q    <= '0;
			l4_sum_q    <= '0;
			held_hi_q   <= '0;
			held_lo_q   <= '0;
			held_port_q <= '0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && meta_s3.is_src;
			if (valid_s3) begin
				ip_sum_q <= ip_new;
				l4_sum_q <= l4_new;
				if (!meta_s3.is_src) begin
					held_hi_q   <= meta_s3.res_hi;
					held_lo_q   <= meta_s3.res_lo;
					held_port_q <= meta_s3.res_port;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_c;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			word_s1 <= word_c;
			for (int j = 0; j < ADDR_WORDS/2; j++) begin
				pair_s2[j] <= oc_add(word_s1[2*j], word_s1[2*j+1]);
			end
			quad_s3[0] <= oc_add(pair_s2[0], pair_s2[1]);
			quad_s3[1] <= oc_add(pair_s2[2], pair_s2[3]);
			if (valid_s3 && meta_s3.is_src) begin
				out_ip_checksum <= meta_s3.ip6 ? ip_new : ~ip_new;
				out_l4_checksum <= meta_s3.l4_act ? ~l4_new : l4_new;
				out_dst_addr_hi <= held_hi_q;
				out_dst_addr_lo <= held_lo_q;
				out_src_addr_hi <= meta_s3.res_hi;
				out_src_addr_lo <= meta_s3.res_lo;
				out_dst_port    <= held_port_q;
				out_src_port    <= meta_s3.res_port;
			end
		end
	end

endmodule

>>> hdl/nat_header_rewrite_incremental_csum.sv
// NAT header rewrite with incremental checksum update: top level.
//
// Input channel (in_valid/in_ready): one transaction per packet side. A packet is a
// destination transaction (operation 0, carries header kind and received checksums)
// followed by a source transaction (operation 1). Only the source transaction
// produces a result on the output channel (out_valid/out_ready).
// A zero new address or port keeps the current one. The IPv4 header checksum (any
// protocol) and, for TCP/UDP with a nonzero L4 checksum, the L4 checksum are updated
// with end-around-carry one's-complement adds; a zero L4 checksum stays zero and both
// ports take the given value.
// Path: a source transaction is written into the queue, then passes three adder-tree
// stages (s1, s2, s3) ahead of the result register.
// Throughput: one transaction per cycle unless the back end stalls on out_ready low;
// every stage is pipelined, so a new transaction enters before the last is through.
// Stall: the front end keeps accepting while the queue has room; when the result
// register is held by out_ready low, the back end freezes and the queue fills,
// then in_ready drops. Reset clears the queue, the pipeline, the header kind and
// the held destination side and checksum sums to zero.
module nat_header_rewrite_incremental_csum #(
	parameter int unsigned QUEUE_DEPTH = nhrc_pkg::QUEUE_DEPTH_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic        is_ip6,
	input  logic [7:0]  protocol,
	input  logic [15:0] ip_checksum,
	input  logic [15:0] l4_checksum,
	input  logic [63:0] old_addr_hi,
	input  logic [63:0] old_addr_lo,
	input  logic [63:0] new_addr_hi,
	input  logic [63:0] new_addr_lo,
	input  logic [15:0] cur_port,
	input  logic [15:0] xlat_port,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_ip_checksum,
	output logic [15:0] out_l4_checksum,
	output logic [63:0] out_dst_addr_hi,
	output logic [63:0] out_dst_addr_lo,
	output logic [63:0] out_src_addr_hi,
	output logic [63:0] out_src_addr_lo,
	output logic [15:0] out_dst_port,
	output logic [15:0] out_src_port
);
	import nhrc_pkg::*;

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// Front-to-queue transaction.
	logic    q_push, q_push_ready;
	item_t   q_push_item;
	// Queue-to-back transaction.
	logic    q_pop_valid, q_pop;
	item_t   q_pop_item;
	logic [CW-1:0] q_count;

	// Classify each transaction and tag it with the packet's header kind.
	nhrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.is_ip6      (is_ip6),
		.protocol    (protocol),
		.ip_checksum (ip_checksum),
		.l4_checksum (l4_checksum),
		.old_addr_hi (old_addr_hi),
		.old_addr_lo (old_addr_lo),
		.new_addr_hi (new_addr_hi),
		.new_addr_lo (new_addr_lo),
		.cur_port    (cur_port),
		.xlat_port   (xlat_port),
		.push        (q_push),
		.push_ready  (q_push_ready),
		.push_item   (q_push_item)
	);

	// Decouple acceptance from the checksum pipeline.
	nhrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_push_ready),
		.push_item  (q_push_item),
		.pop_valid  (q_pop_valid),
		.pop        (q_pop),
		.pop_item   (q_pop_item),
		.count      (q_count)
	);

	// Fold checksum deltas, hold the destination side, emit the packet result.
	nhrc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_pop_valid),
		.q_item          (q_pop_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_ip_checksum (out_ip_checksum),
		.out_l4_checksum (out_l4_checksum),
		.out_dst_addr_hi (out_dst_addr_hi),
		.out_dst_addr_lo (out_dst_addr_lo),
		.out_src_addr_hi (out_src_addr_hi),
		.out_src_addr_lo (out_src_addr_lo),
		.out_dst_port    (out_dst_port),
		.out_src_port    (out_src_port)
	);

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == '0) |-> !q_pop)
		else $error("pop from empty queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_count == $past(q_count) + CW'(1)))
		else $error("queue lost a pushed transaction");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == CW'(QUEUE_DEPTH)) |-> !in_ready)
		else $error("input accepted while queue full");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the NAT header rewrite block with incremental checksum update.
`timescale 1ns / 100ps

module tb_top;
	import nhrc_pkg::*;

	// Cycles without any transaction before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 1000;
	// Length of the forced receiver hold-off that backs the block up.
	localparam int unsigned HOLD_CYCLES = 80;
	// Extra drain time after the last expected header, to catch stray results.
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS = 125;
	localparam int unsigned DIR_ROWS = 23;

	// One input transaction, one field per port.
	typedef struct {
		logic        op;
		logic        ip6;
		logic [7:0]  proto;
		logic [15:0] ip_ck;
		logic [15:0] l4_ck;
		logic [63:0] old_hi;
		logic [63:0] old_lo;
		logic [63:0] new_hi;
		logic [63:0] new_lo;
		logic [15:0] old_pt;
		logic [15:0] new_pt;
	} stim_t;

	// One rewritten header as it leaves the block.
	typedef struct {
		logic [15:0] ip_ck;
		logic [15:0] l4_ck;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [15:0] dst_pt;
		logic [15:0] src_pt;
	} result_t;

	// Directed row: a transaction plus, where obvious, the header it must yield.
	typedef struct {
		stim_t   s;
		logic    typed;
		result_t r;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic        is_ip6;
	logic [7:0]  protocol;
	logic [15:0] ip_checksum;
	logic [15:0] l4_checksum;
	logic [63:0] old_addr_hi;
	logic [63:0] old_addr_lo;
	logic [63:0] new_addr_hi;
	logic [63:0] new_addr_lo;
	logic [15:0] cur_port;
	logic [15:0] xlat_port;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] out_ip_checksum;
	logic [15:0] out_l4_checksum;
	logic [63:0] out_dst_addr_hi;
	logic [63:0] out_dst_addr_lo;
	logic [63:0] out_src_addr_hi;
	logic [63:0] out_src_addr_lo;
	logic [15:0] out_dst_port;
	logic [15:0] out_src_port;

	nat_header_rewrite_incremental_csum DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.is_ip6          (is_ip6),
		.protocol        (protocol),
		.ip_checksum     (ip_checksum),
		.l4_checksum     (l4_checksum),
		.old_addr_hi     (old_addr_hi),
		.old_addr_lo     (old_addr_lo),
		.new_addr_hi     (new_addr_hi),
		.new_addr_lo     (new_addr_lo),
		.cur_port        (cur_port),
		.xlat_port       (xlat_port),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_ip_checksum (out_ip_checksum),
		.out_l4_checksum (out_l4_checksum),
		.out_dst_addr_hi (out_dst_addr_hi),
		.out_dst_addr_lo (out_dst_addr_lo),
		.out_src_addr_hi (out_src_addr_hi),
		.out_src_addr_lo (out_src_addr_lo),
		.out_dst_port    (out_dst_port),
		.out_src_port    (out_src_port)
	);

	// Shadow of the block's packet state, advanced at each accepted transaction.
	logic        hdr_ip6;
	logic [7:0]  hdr_proto;
	logic [15:0] ip_acc;
	logic [15:0] l4_acc;
	logic [63:0] held_hi;
	logic [63:0] held_lo;
	logic [15:0] held_pt;
	logic        l4_zero;

	result_t     pending_rewrites[$];
	result_t     want;
	row_t        dir_tab[0:DIR_ROWS-1];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	int unsigned idle_pct;
	int unsigned stall_pct;
	logic        pressure_go;
	logic        pressure_done;

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor: one's-complement checksum update, one 16-bit word at a time
	// ---------------------------------------------------------------------

	// Add with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// Take the old word out of a running ~checksum and put the new one in.
	function automatic logic [15:0] ones_swap(input logic [15:0] acc, input logic [15:0] ow,
			input logic [15:0] nw);
		return ones_add(ones_add(acc, ~ow), nw);
	endfunction

	// Rewrite one side of the header against the held packet kind and sums.
	function automatic void rewrite_side(input stim_t s, output logic [63:0] hi,
			output logic [63:0] lo, output logic [15:0] pt);
		logic        tcpudp;
		logic        l4_live;
		logic [63:0] ohi, olo, nhi, nlo, ow, nw;
		int          n_words;
		tcpudp  = (hdr_proto == PROTO_TCP) || (hdr_proto == PROTO_UDP);
		l4_live = tcpudp && !l4_zero;
		ohi = s.old_hi;
		olo = s.old_lo;
		nhi = s.new_hi;
		nlo = s.new_lo;
		n_words = hdr_ip6 ? 8 : 2;
		// IPv4 sees only the low 32 bits; everything above reads as zero
		if (!hdr_ip6) begin
			ohi = '0;
			nhi = '0;
			olo[63:32] = '0;
			nlo[63:32] = '0;
		end
		if ((nhi | nlo) == '0) begin
			hi = ohi;
			lo = olo;
		end else begin
			hi = nhi;
			lo = nlo;
			for (int i = 0; i < n_words; i++) begin
				ow = (i < 4) ? olo : ohi;
				nw = (i < 4) ? nlo : nhi;
				if (l4_live)
					l4_acc = ones_swap(l4_acc, ow[16*(i%4) +: 16], nw[16*(i%4) +: 16]);
				if (!hdr_ip6)
					ip_acc = ones_swap(ip_acc, ow[16*(i%4) +: 16], nw[16*(i%4) +: 16]);
			end
		end
		// Ports: untouched for other protocols, forced for a zero L4 checksum
		if (!tcpudp) begin
			pt = s.old_pt;
		end else if (l4_zero) begin
			pt = s.new_pt;
		end else if (s.new_pt != '0) begin
			pt = s.new_pt;
			l4_acc = ones_swap(l4_acc, s.old_pt, s.new_pt);
		end else begin
			pt = s.old_pt;
		end
	endfunction

	// Advance the shadow state by one transaction; a source side yields a header.
	function automatic void predict_rewrite(input stim_t s, output logic produced,
			output result_t r);
		logic        tcpudp;
		logic [63:0] hi, lo;
		logic [15:0] pt;
		produced = 1'b0;
		r = '{default: '0};
		if (s.op == OP_DST) begin
			hdr_ip6   = s.ip6;
			hdr_proto = s.proto;
			tcpudp    = (s.proto == PROTO_TCP) || (s.proto == PROTO_UDP);
			l4_zero   = tcpudp && (s.l4_ck == '0);
			ip_acc    = s.ip6 ? s.ip_ck : ~s.ip_ck;
			l4_acc    = (tcpudp && s.l4_ck != '0) ? ~s.l4_ck : s.l4_ck;
			rewrite_side(s, hi, lo, pt);
			held_hi = hi;
			held_lo = lo;
			held_pt = pt;
		end else begin
			rewrite_side(s, hi, lo, pt);
			tcpudp = (hdr_proto == PROTO_TCP) || (hdr_proto == PROTO_UDP);
			r.ip_ck  = hdr_ip6 ? ip_acc : ~ip_acc;
			r.l4_ck  = (tcpudp && !l4_zero) ? ~l4_acc : l4_acc;
			r.dst_hi = held_hi;
			r.dst_lo = held_lo;
			r.src_hi = hi;
			r.src_lo = lo;
			r.dst_pt = held_pt;
			r.src_pt = pt;
			produced = 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic stim_t mk(input logic op, input logic ip6, input logic [7:0] proto,
			input logic [15:0] ip_ck, input logic [15:0] l4_ck,
			input logic [63:0] old_hi, input logic [63:0] old_lo,
			input logic [63:0] new_hi, input logic [63:0] new_lo,
			input logic [15:0] old_pt, input logic [15:0] new_pt);
		return '{op, ip6, proto, ip_ck, l4_ck, old_hi, old_lo, new_hi, new_lo,
			old_pt, new_pt};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random transaction of the given side, biased toward TCP/UDP and keep cases.
	function automatic stim_t rand_item(input logic op);
		stim_t       s;
		int unsigned r;
		s.op    = op;
		s.ip6   = 1'($urandom_range(1));
		r = $urandom_range(99);
		s.proto = (r < 40) ? PROTO_TCP : (r < 80) ? PROTO_UDP : 8'($urandom_range(255));
		s.ip_ck = 16'($urandom_range(65535));
		r = $urandom_range(99);
		s.l4_ck = (r < 15) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom_range(65535));
		s.old_hi = rand64();
		s.old_lo = rand64();
		r = $urandom_range(99);
		if (r < 25) begin
			// keep the address
			s.new_hi = '0;
			s.new_lo = '0;
		end else if (r < 35) begin
			// keep for IPv4 only: garbage above the low 32 bits
			s.new_hi = rand64();
			s.new_lo = {$urandom, 32'h0};
		end else if (r < 42) begin
			s.new_hi = '0;
			s.new_lo = rand64();
		end else begin
			s.new_hi = rand64();
			s.new_lo = rand64();
		end
		s.old_pt = 16'($urandom_range(65535));
		s.new_pt = ($urandom_range(99) < 25) ? 16'h0000 : 16'($urandom_range(65535));
		return s;
	endfunction

	// Offer one transaction; hold it until accepted, then log what it must produce.
	task automatic offer(input stim_t s, input logic typed, input result_t tr);
		logic    produced;
		result_t pr;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= s.op;
		is_ip6      <= s.ip6;
		protocol    <= s.proto;
		ip_checksum <= s.ip_ck;
		l4_checksum <= s.l4_ck;
		old_addr_hi <= s.old_hi;
		old_addr_lo <= s.old_lo;
		new_addr_hi <= s.new_hi;
		new_addr_lo <= s.new_lo;
		cur_port    <= s.old_pt;
		xlat_port   <= s.new_pt;
		do
			@(posedge clk);
		while (!in_ready);
		predict_rewrite(s, produced, pr);
		if (produced)
			pending_rewrites.push_back(typed ? tr : pr);
	endtask

	// Run one idling phase of random traffic, mostly well-formed packets.
	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned n;
		int unsigned r;
		result_t     none;
		none = '{default: '0};
		idle_pct  = send_pct;
		stall_pct = recv_pct;
		n = 0;
		while (n < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 85) begin
				offer(rand_item(OP_DST), 1'b0, none);
				offer(rand_item(OP_SRC), 1'b0, none);
				n += 2;
			end else if (r < 93) begin
				// source side with no fresh destination side
				offer(rand_item(OP_SRC), 1'b0, none);
				n += 1;
			end else begin
				// destination side that the next one overwrites
				offer(rand_item(OP_DST), 1'b0, none);
				n += 1;
			end
		end
	endtask

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp_v);
		if (got !== exp_v)
			report($sformatf("%s got %h expected %h", name, got, exp_v));
	endtask

	// ---------------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------------

	function automatic void load_table();
		result_t none;
		none = '{default: '0};
		// Source side straight after reset: IPv4, protocol 0, all sums zero
		dir_tab[0]  = '{mk(OP_SRC, 1'b0, 8'd0, 16'h0, 16'h0, 64'h0, 64'h0, 64'h0, 64'h0,
			16'h1234, 16'h0), 1'b1,
			'{16'hFFFF, 16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 16'h0000, 16'h1234}};
		// TCP with zero L4 checksum: ports forced (even to zero), checksum stays zero
		dir_tab[1]  = '{mk(OP_DST, 1'b0, PROTO_TCP, 16'hABCD, 16'h0000, 64'h0, 64'h0A000001,
			64'h0, 64'h0, 16'h0050, 16'h0000), 1'b0, none};
		dir_tab[2]  = '{mk(OP_SRC, 1'b0, 8'd0, 16'h0, 16'h0, 64'h0, 64'h0B000002, 64'h0,
			64'h0, 16'h03E8, 16'h07D0), 1'b1,
			'{16'hABCD, 16'h0000, 64'h0, 64'h0A000001, 64'h0, 64'h0B000002, 16'h0000,
			16'h07D0}};
		// IPv4 TCP, both sides rewritten
		dir_tab[3]  = '{mk(OP_DST, 1'b0, PROTO_TCP, 16'h1C46, 16'hB1E6, 64'h0, 64'hC0A80001,
			64'h0, 64'h0A000001, 16'h1F90, 16'h0050), 1'b0, none};
		dir_tab[4]  = '{mk(OP_SRC, 1'b0, PROTO_TCP, 16'h0, 16'h0, 64'h0, 64'hC0A80064, 64'h0,
			64'h64400001, 16'hC350, 16'h8000), 1'b0, none};
		// IPv6 UDP, address extremes
		dir_tab[5]  = '{mk(OP_DST, 1'b1, PROTO_UDP, 16'h0000, 16'h0001, '1, '1,
			64'h20010DB800000000, 64'h1, 16'hFFFF, 16'h0001), 1'b0, none};
		dir_tab[6]  = '{mk(OP_SRC, 1'b1, PROTO_UDP, 16'hFFFF, 16'hFFFF, 64'h0, 64'h0, '1, '1,
			16'h0000, 16'hFFFF), 1'b0, none};
		// Other protocol: addresses change, ports and L4 checksum pass through
		dir_tab[7]  = '{mk(OP_DST, 1'b0, 8'd1, 16'hFFFF, 16'h1234, 64'h0, 64'h0A0A0A0A, 64'h0,
			64'h0B0B0B0B, 16'h1111, 16'h2222), 1'b0, none};
		dir_tab[8]  = '{mk(OP_SRC, 1'b0, 8'd1, 16'h0, 16'h0, 64'h0, 64'h0C0C0C0C, 64'h0,
			64'h0D0D0D0D, 16'h3333, 16'h4444), 1'b0, none};
		// IPv6, protocol 255, addresses kept
		dir_tab[9]  = '{mk(OP_DST, 1'b1, 8'hFF, 16'h8001, 16'h0000, 64'h0123456789ABCDEF,
			64'hFEDCBA9876543210, 64'h0, 64'h0, 16'h0101, 16'h0202), 1'b0, none};
		dir_tab[10] = '{mk(OP_SRC, 1'b1, 8'hFF, 16'h0, 16'h0, 64'h5555AAAA5555AAAA,
			64'hAAAA5555AAAA5555, 64'h0, 64'h0, 16'h0303, 16'h0404), 1'b0, none};
		// IPv4 keep test sees only the low 32 bits; upper bits are ignored
		dir_tab[11] = '{mk(OP_DST, 1'b0, PROTO_TCP, 16'h0000, 16'hFFFF, 64'hDEADBEEFDEADBEEF,
			64'hFFFFFFFF01020304, 64'h1234, 64'hFFFFFFFF00000000, 16'h0000, 16'h0000),
			1'b0, none};
		dir_tab[12] = '{mk(OP_SRC, 1'b0, PROTO_TCP, 16'h0, 16'h0, 64'hFFFFFFFFFFFFFFFF,
			64'h8000000080000000, 64'h0, 64'h00000001C0A80101, 16'hFFFF, 16'h0001), 1'b0,
			none};
		// Updated L4 checksum lands on zero and is emitted as zero
		dir_tab[13] = '{mk(OP_DST, 1'b0, PROTO_UDP, 16'hFFFF, 16'hFFFF, 64'h0, 64'h01020304,
			64'h0, 64'h0, 16'h0001, 16'h0001), 1'b0, none};
		dir_tab[14] = '{mk(OP_SRC, 1'b0, PROTO_UDP, 16'h0, 16'h0, 64'h0, 64'h05060708, 64'h0,
			64'h0, 16'h0002, 16'h0000), 1'b0, none};
		// Two destination sides in a row: the second one wins
		dir_tab[15] = '{mk(OP_DST, 1'b0, PROTO_TCP, 16'h1111, 16'h2222, 64'h0, 64'h11111111,
			64'h0, 64'h22222222, 16'h1111, 16'h2222), 1'b0, none};
		dir_tab[16] = '{mk(OP_DST, 1'b1, PROTO_UDP, 16'h5555, 16'h7777, 64'h1, 64'h2,
			64'h3, 64'h4, 16'h5555, 16'h6666), 1'b0, none};
		dir_tab[17] = '{mk(OP_SRC, 1'b1, PROTO_UDP, 16'h0, 16'h0, 64'h7, 64'h8, 64'h0, 64'h9,
			16'h7777, 16'h8888), 1'b0, none};
		// Source side with no destination side in front of it
		dir_tab[18] = '{mk(OP_SRC, 1'b0, 8'd0, 16'h0, 16'h0, 64'hA, 64'hB, 64'hC, 64'hD,
			16'h9999, 16'hAAAA), 1'b0, none};
		// IPv6 TCP, port extremes, smallest nonzero L4 checksum
		dir_tab[19] = '{mk(OP_DST, 1'b1, PROTO_TCP, 16'h0000, 16'h0001, '1, 64'h0, 64'h0, '1,
			16'hFFFF, 16'hFFFF), 1'b0, none};
		dir_tab[20] = '{mk(OP_SRC, 1'b1, PROTO_TCP, 16'h0, 16'h0, 64'h0, '1, '1, 64'h0,
			16'hFFFF, 16'hFFFF), 1'b0, none};
		// IPv6 UDP, zero L4 checksum, both ports written as zero
		dir_tab[21] = '{mk(OP_DST, 1'b1, PROTO_UDP, 16'h4321, 16'h0000, 64'h10, 64'h20,
			64'h30, 64'h40, 16'h1234, 16'h0000), 1'b0, none};
		dir_tab[22] = '{mk(OP_SRC, 1'b1, PROTO_UDP, 16'h0, 16'h0, 64'h50, 64'h60, 64'h70,
			64'h80, 16'h4321, 16'h0000), 1'b0, none};
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off to back the block up
	// ---------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !pressure_done) begin
				// hold off while the sender keeps offering; the queue fills and in_ready drops
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				pressure_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: compare each header against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_rewrites.size() == 0) begin
				report("result with no packet outstanding");
			end else begin
				want = pending_rewrites.pop_front();
				check_field("out_ip_checksum", 64'(out_ip_checksum), 64'(want.ip_ck));
				check_field("out_l4_checksum", 64'(out_l4_checksum), 64'(want.l4_ck));
				check_field("out_dst_addr_hi", out_dst_addr_hi, want.dst_hi);
				check_field("out_dst_addr_lo", out_dst_addr_lo, want.dst_lo);
				check_field("out_src_addr_hi", out_src_addr_hi, want.src_hi);
				check_field("out_src_addr_lo", out_src_addr_lo, want.src_lo);
				check_field("out_dst_port", 64'(out_dst_port), 64'(want.dst_pt));
				check_field("out_src_port", 64'(out_src_port), 64'(want.src_pt));
			end
		end
	end

	// Watchdog: drop the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_DST;
		is_ip6        = 1'b0;
		protocol      = '0;
		ip_checksum   = '0;
		l4_checksum   = '0;
		old_addr_hi   = '0;
		old_addr_lo   = '0;
		new_addr_hi   = '0;
		new_addr_lo   = '0;
		cur_port      = '0;
		xlat_port     = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		pressure_go   = 1'b0;
		pressure_done = 1'b0;
		mismatch_count = 0;
		hdr_ip6   = 1'b0;
		hdr_proto = '0;
		ip_acc    = '0;
		l4_acc    = '0;
		held_hi   = '0;
		held_lo   = '0;
		held_pt   = '0;
		l4_zero   = 1'b0;
		load_table();

		// Hold reset, then release it on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows, back to back
		for (int i = 0; i < DIR_ROWS; i++)
			offer(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].r);

		// Random traffic; the first phase carries the long receiver hold-off
		pressure_go = 1'b1;
		run_phase(0, 0);
		run_phase(51, 0);
		run_phase(0, 51);
		run_phase(17, 17);

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: wait out every expected header, then watch for strays
		while (pending_rewrites.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
